### sv/chd_pkg.sv
// Shared types, codes and character constants for the chunked body decoder.
// No dependencies; imported by chd_step and http_chunked_decoder_core.
package chd_pkg;

  localparam int LengthBitsDefault = 32;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  // phases
  localparam logic [1:0] PH_HEAD  = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_TRAIL = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // substeps inside header and trailer lines
  localparam logic [2:0] SS_NONE  = 3'd0;
  localparam logic [2:0] SS_CR    = 3'd1;
  localparam logic [2:0] SS_LF    = 3'd2;
  localparam logic [2:0] SS_FIRST = 3'd3;
  localparam logic [2:0] SS_LEN   = 3'd4;
  localparam logic [2:0] SS_EXT   = 3'd5;
  localparam logic [2:0] SS_EOL   = 3'd6;
  // trailer reuses codes: text line, line CR seen, empty line CR seen
  localparam logic [2:0] TS_START = 3'd1;
  localparam logic [2:0] TS_TEXT  = 3'd2;
  localparam logic [2:0] TS_LF    = 3'd3;
  localparam logic [2:0] TS_END   = 3'd5;

  // result kinds
  localparam logic [2:0] K_FRAME = 3'd0;
  localparam logic [2:0] K_DATA  = 3'd1;
  localparam logic [2:0] K_END   = 3'd2;
  localparam logic [2:0] K_ERR   = 3'd3;
  localparam logic [2:0] K_IGN   = 3'd4;

  // error codes
  localparam logic [2:0] E_NONE  = 3'd0;
  localparam logic [2:0] E_CR    = 3'd1;
  localparam logic [2:0] E_LF    = 3'd2;
  localparam logic [2:0] E_FIRST = 3'd3;
  localparam logic [2:0] E_LEN   = 3'd4;
  localparam logic [2:0] E_OVF   = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [2:0] error_code;
  } chd_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } chd_hex_t;

  function automatic chd_hex_t hex_decode(input logic [7:0] b);
    chd_hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (b >= CH_ZERO && b <= CH_ZERO + 8'd9) begin
      h.value = 4'(b - CH_ZERO);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h41 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

### sv/chd_step.sv
// Next-state and result logic for one body byte of the chunked decoder.
// Purely combinational; uses chd_pkg for codes and the hex decoder.
module chd_step
  import chd_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDefault
) (
  input  logic [7:0]             byte_i,
  input  logic [1:0]             phase_i,
  input  logic [2:0]             substep_i,
  input  logic [LENGTH_BITS-1:0] bytes_left_i,
  input  logic [2:0]             sticky_i,
  output logic [1:0]             phase_o,
  output logic [2:0]             substep_o,
  output logic [LENGTH_BITS-1:0] bytes_left_o,
  output logic [2:0]             sticky_o,
  output chd_result_t            result_o
);

  chd_hex_t               hex;
  logic [LENGTH_BITS-1:0] dec;
  logic [2:0]             kind;
  logic [2:0]             fail_code;

  assign hex = hex_decode(byte_i);
  assign dec = (bytes_left_i != '0) ? bytes_left_i - LENGTH_BITS'(1) : bytes_left_i;

  always_comb begin
    phase_o      = phase_i;
    substep_o    = substep_i;
    bytes_left_o = bytes_left_i;
    sticky_o     = sticky_i;
    kind         = K_FRAME;
    fail_code    = E_NONE;
    result_o     = '0;

    if (sticky_i != E_NONE) begin
      kind = K_ERR;
    end else begin
      unique case (phase_i)
        PH_HEAD: begin
          case (substep_i)
            SS_CR: begin
              if (byte_i != CH_CR) fail_code = E_CR;
              else                 substep_o = SS_LF;
            end
            SS_LF: begin
              if (byte_i != CH_LF) fail_code = E_LF;
              else                 substep_o = SS_FIRST;
            end
            SS_FIRST: begin
              if (hex.ok) begin
                bytes_left_o = LENGTH_BITS'(hex.value);
                substep_o    = SS_LEN;
              end else if (byte_i != CH_SPACE) begin
                fail_code = E_FIRST;
              end
            end
            SS_LEN: begin
              if (hex.ok) begin
                // refuse a digit that would push bits off the top
                if (bytes_left_i[LENGTH_BITS-1 -: 4] != 4'd0) begin
                  fail_code = E_OVF;
                end else begin
                  bytes_left_o = {bytes_left_i[LENGTH_BITS-5:0], hex.value};
                end
              end else if (byte_i == CH_SEMI) begin
                substep_o = SS_EXT;
              end else if (byte_i == CH_CR) begin
                substep_o = SS_EOL;
              end else if (byte_i != CH_SPACE) begin
                fail_code = E_LEN;
              end
            end
            SS_EXT: begin
              if (byte_i == CH_CR) substep_o = SS_EOL;
            end
            SS_EOL: begin
              if (byte_i != CH_LF) begin
                fail_code = E_LF;
              end else if (bytes_left_i != '0) begin
                phase_o = PH_DATA;
              end else begin
                phase_o   = PH_TRAIL;
                substep_o = SS_CR;
              end
            end
            default: substep_o = SS_CR;
          endcase
        end
        PH_DATA: begin
          kind         = K_DATA;
          result_o.data = byte_i;
          bytes_left_o = dec;
          if (dec == '0) begin
            phase_o   = PH_HEAD;
            substep_o = SS_CR;
          end
        end
        PH_TRAIL: begin
          case (substep_i)
            TS_START: substep_o = (byte_i == CH_CR) ? TS_END : TS_TEXT;
            TS_TEXT: begin
              if (byte_i == CH_CR) substep_o = TS_LF;
            end
            TS_LF: begin
              if (byte_i != CH_LF) fail_code = E_LF;
              else                 substep_o = TS_START;
            end
            TS_END: begin
              if (byte_i != CH_LF) begin
                fail_code = E_LF;
              end else begin
                phase_o   = PH_DONE;
                substep_o = SS_NONE;
                kind      = K_END;
              end
            end
            default: substep_o = TS_START;
          endcase
        end
        default: kind = K_IGN;
      endcase

      if (fail_code != E_NONE) begin
        // failing byte changes nothing but the sticky code
        phase_o      = phase_i;
        substep_o    = substep_i;
        bytes_left_o = bytes_left_i;
        sticky_o     = fail_code;
        kind         = K_ERR;
      end
    end

    result_o.kind       = kind;
    result_o.error_code = (kind == K_ERR) ? sticky_o : E_NONE;
  end

endmodule

### sv/http_chunked_decoder_core.sv
// Chunked transfer body decoder: one raw byte in, one classified word out per byte.
// Top level; instantiates chd_step and uses chd_pkg.
//
// Each accepted byte yields exactly one output word: the byte is held in the input
// register, stepped and written to the output register; a stalled output word holds
// the next byte in the input register. A new byte is taken every clock as long as
// out_stall is low. The throughput is one byte per cycle, bounded by the single step
// stage that updates the decoder state between the input register and the output
// register. The length counter is LENGTH_BITS wide; a size line with more significant
// digits than fit is reported as an overflow error. Errors are sticky until reset.
module http_chunked_decoder_core
  import chd_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_error_code
);

  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic                   out_valid_r;
  chd_result_t            out_r;

  logic [1:0]             phase_r,      phase_nxt;
  logic [2:0]             substep_r,    substep_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [2:0]             sticky_r,     sticky_nxt;
  chd_result_t            result;

  logic                   advance;
  logic                   take;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign take     = in_valid && !in_stall;
  assign in_stall = s1_valid_r && !advance;

  chd_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .byte_i       (s1_byte_r),
    .phase_i      (phase_r),
    .substep_i    (substep_r),
    .bytes_left_i (bytes_left_r),
    .sticky_i     (sticky_r),
    .phase_o      (phase_nxt),
    .substep_o    (substep_nxt),
    .bytes_left_o (bytes_left_nxt),
    .sticky_o     (sticky_nxt),
    .result_o     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_HEAD;
      substep_r    <= SS_FIRST;
      bytes_left_r <= '0;
      sticky_r     <= E_NONE;
    end else begin
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        phase_r      <= phase_nxt;
        substep_r    <= substep_nxt;
        bytes_left_r <= bytes_left_nxt;
        sticky_r     <= sticky_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) s1_byte_r <= in_byte;
    if (advance) out_r <= result;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_byte       = out_r.data;
  assign out_error_code = out_r.error_code;

endmodule
